// File: rtl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

   localparam int DIM       = 4;
   localparam int LANES     = 4;
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int ACC_W     = PROD_W + $clog2(DIM);
   localparam int Q_W       = ACC_W - FRAC_BITS;
   localparam int IDX_W     = $clog2(DIM);

   localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(DIM - 1);
   localparam logic [DATA_W-1:0] SAT_POS  = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_NEG  = {1'b1, {(DATA_W-1){1'b0}}};

   localparam logic [1:0] KIND_LOAD_LEFT  = 2'd0;
   localparam logic [1:0] KIND_LOAD_RIGHT = 2'd1;
   localparam logic [1:0] KIND_MULTIPLY   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT_OUT,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         row_index;
      logic signed [31:0] elem_a;
      logic signed [31:0] elem_b;
      logic signed [31:0] elem_c;
      logic signed [31:0] elem_d;
   } req_type;

   typedef struct packed {
      logic [1:0]         out_row;
      logic signed [31:0] prod_a;
      logic signed [31:0] prod_b;
      logic signed [31:0] prod_c;
      logic signed [31:0] prod_d;
      logic               saturated;
      logic               last_row;
   } rsp_type;

   typedef struct packed {
      logic               step;
      logic               first;
      logic               last;
      logic [IDX_W-1:0]   k;
      logic [DATA_W-1:0]  left_elem;
   } issue_type;

   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   row;
      logic [DATA_W-1:0]  data;
   } col_wr_type;

   typedef struct packed {
      logic               valid;
      logic               sat;
      logic [DATA_W-1:0]  value;
   } lane_res_type;

endpackage

// File: rtl/mm4_lane.sv
// ----------------------------------------------------------------------------
// mm4_lane
// One product column: holds its column of the right operand, multiplies,
// accumulates over the inner index, then truncates and saturates.
// ----------------------------------------------------------------------------
module mm4_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  mm4_pkg::col_wr_type   col_wr,
   input  mm4_pkg::issue_type    issue,
   output mm4_pkg::lane_res_type res
);

   logic [mm4_pkg::DATA_W-1:0]        col_ff [mm4_pkg::DIM];
   logic signed [mm4_pkg::DATA_W-1:0] a_op;
   logic signed [mm4_pkg::DATA_W-1:0] b_op;
   logic signed [mm4_pkg::PROD_W-1:0] prod_in;
   logic signed [mm4_pkg::PROD_W-1:0] prod_ff;
   logic                              p_valid_ff;
   logic                              p_first_ff;
   logic                              p_last_ff;
   logic [mm4_pkg::ACC_W-1:0]         acc_in;
   logic [mm4_pkg::ACC_W-1:0]         acc_ff;
   logic                              done_ff;
   logic [mm4_pkg::ACC_W-1:0]         biased;
   logic [mm4_pkg::Q_W-1:0]           quot;
   logic                              neg;
   logic                              fits;
   logic [mm4_pkg::DATA_W-1:0]        value_in;
   logic                              sat_in;
   logic                              res_valid_ff;
   logic                              res_sat_ff;
   logic [mm4_pkg::DATA_W-1:0]        res_value_ff;

   assign a_op    = issue.left_elem;
   assign b_op    = col_ff[issue.k];
   assign prod_in = a_op * b_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mm4_pkg::DIM; i++) begin
            col_ff[i] <= '0;
         end
      end else if (col_wr.en) begin
         col_ff[col_wr.row] <= col_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         done_ff      <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= issue.step;
         done_ff      <= p_valid_ff & p_last_ff;
         res_valid_ff <= done_ff;
      end
   end

   always_comb begin
      if (p_first_ff) begin
         acc_in = {{(mm4_pkg::ACC_W-mm4_pkg::PROD_W){prod_ff[mm4_pkg::PROD_W-1]}}, prod_ff};
      end else begin
         acc_in = acc_ff
                + {{(mm4_pkg::ACC_W-mm4_pkg::PROD_W){prod_ff[mm4_pkg::PROD_W-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (issue.step) begin
         prod_ff    <= prod_in;
         p_first_ff <= issue.first;
         p_last_ff  <= issue.last;
      end
      if (p_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (done_ff) begin
         res_value_ff <= value_in;
         res_sat_ff   <= sat_in;
      end
   end

   assign res.valid = res_valid_ff;
   assign res.sat   = res_sat_ff;
   assign res.value = res_value_ff;

   // truncate toward zero: bias negative sums before the arithmetic shift
   always_comb begin
      neg    = acc_ff[mm4_pkg::ACC_W-1];
      biased = acc_ff + {{(mm4_pkg::ACC_W-mm4_pkg::FRAC_BITS){1'b0}},
                         {mm4_pkg::FRAC_BITS{neg}}};
      quot   = biased[mm4_pkg::ACC_W-1:mm4_pkg::FRAC_BITS];
      fits   = (&quot[mm4_pkg::Q_W-1:mm4_pkg::DATA_W-1])
             | ~(|quot[mm4_pkg::Q_W-1:mm4_pkg::DATA_W-1]);
      sat_in = ~fits;
      if (fits) begin
         value_in = quot[mm4_pkg::DATA_W-1:0];
      end else if (neg) begin
         value_in = mm4_pkg::SAT_NEG;
      end else begin
         value_in = mm4_pkg::SAT_POS;
      end
   end

endmodule

// File: rtl/mm4_merge.sv
// ----------------------------------------------------------------------------
// mm4_merge
// Combines the lane results of one product row into a result item and
// holds it in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module mm4_merge (
   input  logic                           clock,
   input  logic                           reset,
   input  mm4_pkg::lane_res_type          lanes [mm4_pkg::LANES],
   input  logic [mm4_pkg::IDX_W-1:0]      row,
   output logic                           land,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mm4_pkg::rsp_type               rsp_data
);

   logic             rsp_valid_ff;
   mm4_pkg::rsp_type rsp_data_ff;
   mm4_pkg::rsp_type rsp_data_in;
   logic             sat_any;

   always_comb begin
      land    = 1'b1;
      sat_any = 1'b0;
      for (int i = 0; i < mm4_pkg::LANES; i++) begin
         land    = land & lanes[i].valid;
         sat_any = sat_any | lanes[i].sat;
      end
      rsp_data_in.out_row   = 2'(row);
      rsp_data_in.prod_a    = lanes[0].value;
      rsp_data_in.prod_b    = lanes[1].value;
      rsp_data_in.prod_c    = lanes[2].value;
      rsp_data_in.prod_d    = lanes[3].value;
      rsp_data_in.saturated = sat_any;
      rsp_data_in.last_row  = (row == mm4_pkg::IDX_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (land) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // a row lands only into an empty register, so no hold check here
   always_ff @(posedge clock) begin
      if (land) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/matrix_multiply_4x4.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// 4x4 signed Q16.16 matrix multiplier with row loads and optional chaining.
//
// Request channel (req_valid/req_stall/req_data): a load item writes one row
// of the left or right operand and is taken while idle. A multiply item
// emits four result items on the response channel, rows 0 to 3, the last
// marked with last_row. Each element is the exact sum of four products,
// truncated toward zero to Q16.16 and saturated; saturated flags the row.
// req_stall is high from a multiply until its last row sits in the output
// register. Four column lanes, each with one 32x32 multiplier, take one
// inner-product step per cycle, so a row needs four issue steps and then
// passes the multiply, accumulate and round registers before it lands.
// req_stall drops in the same cycle that the last row is presented.
// Issue of a row waits until the output register is empty, so a stall
// on rsp_stall holds the row and pauses the sequence.
// With csr chain mode set, each product row overwrites the matching left
// operand row as it lands. Reset clears both operands and the chain mode bit.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mm4_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mm4_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   mm4_pkg::state_type      state_ff;
   mm4_pkg::state_type      state_in;
   logic [mm4_pkg::IDX_W-1:0] k_ff;
   logic [mm4_pkg::IDX_W-1:0] r_ff;
   logic                    chain_mode_ff;
   logic [mm4_pkg::DATA_W-1:0] left_ff [mm4_pkg::DIM][mm4_pkg::LANES];
   logic [mm4_pkg::DATA_W-1:0] req_elem [mm4_pkg::LANES];
   logic                    req_accept;
   logic                    land;
   mm4_pkg::issue_type      issue;
   mm4_pkg::col_wr_type     col_wr [mm4_pkg::LANES];
   mm4_pkg::lane_res_type   lane_res [mm4_pkg::LANES];

   assign req_accept  = req_valid & ~req_stall;
   assign req_elem[0] = req_data.elem_a;
   assign req_elem[1] = req_data.elem_b;
   assign req_elem[2] = req_data.elem_c;
   assign req_elem[3] = req_data.elem_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         chain_mode_ff <= csr_wr_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mm4_pkg::ST_IDLE: begin
            if (req_accept && req_data.kind == mm4_pkg::KIND_MULTIPLY) begin
               state_in = mm4_pkg::ST_WAIT_OUT;
            end
         end
         mm4_pkg::ST_WAIT_OUT: begin
            if (!rsp_valid) begin
               state_in = mm4_pkg::ST_ISSUE;
            end
         end
         mm4_pkg::ST_ISSUE: begin
            if (k_ff == mm4_pkg::IDX_LAST) begin
               state_in = mm4_pkg::ST_DRAIN;
            end
         end
         mm4_pkg::ST_DRAIN: begin
            if (land) begin
               state_in = (r_ff == mm4_pkg::IDX_LAST) ? mm4_pkg::ST_IDLE
                                                      : mm4_pkg::ST_WAIT_OUT;
            end
         end
         default: state_in = mm4_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != mm4_pkg::ST_IDLE);
      issue.step      = (state_ff == mm4_pkg::ST_ISSUE);
      issue.first     = (k_ff == '0);
      issue.last      = (k_ff == mm4_pkg::IDX_LAST);
      issue.k         = k_ff;
      issue.left_elem = left_ff[r_ff][k_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm4_pkg::ST_IDLE;
         k_ff     <= '0;
         r_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == mm4_pkg::ST_IDLE) begin
            k_ff <= '0;
            r_ff <= '0;
         end else if (state_ff == mm4_pkg::ST_ISSUE) begin
            k_ff <= k_ff + 1'b1;
         end else if (state_ff == mm4_pkg::ST_DRAIN && land) begin
            r_ff <= r_ff + 1'b1;
         end
      end
   end

   // left operand: row loads, and product rows written back in chain mode
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < mm4_pkg::DIM; r++) begin
            for (int c = 0; c < mm4_pkg::LANES; c++) begin
               left_ff[r][c] <= '0;
            end
         end
      end else if (req_accept && req_data.kind == mm4_pkg::KIND_LOAD_LEFT) begin
         for (int c = 0; c < mm4_pkg::LANES; c++) begin
            left_ff[req_data.row_index][c] <= req_elem[c];
         end
      end else if (land && chain_mode_ff) begin
         for (int c = 0; c < mm4_pkg::LANES; c++) begin
            left_ff[r_ff][c] <= lane_res[c].value;
         end
      end
   end

   for (genvar c = 0; c < mm4_pkg::LANES; c++) begin : g_lane
      assign col_wr[c].en   = req_accept && req_data.kind == mm4_pkg::KIND_LOAD_RIGHT;
      assign col_wr[c].row  = req_data.row_index;
      assign col_wr[c].data = req_elem[c];

      mm4_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .col_wr (col_wr[c]),
         .issue  (issue),
         .res    (lane_res[c])
      );
   end

   mm4_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .lanes     (lane_res),
      .row       (r_ff),
      .land      (land),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_land_in_drain: assert property (@(posedge clock) disable iff (reset)
      land |-> state_ff == mm4_pkg::ST_DRAIN)
      else $error("product row landed outside drain");

   a_land_into_empty: assert property (@(posedge clock) disable iff (reset)
      land |-> !rsp_valid)
      else $error("product row landed on a full output register");

   a_issue_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mm4_pkg::ST_ISSUE && k_ff == mm4_pkg::IDX_LAST)
      |=> state_ff == mm4_pkg::ST_DRAIN)
      else $error("issue did not end after the last inner step");
`endif

endmodule
